[hdl/mnhr_pkg.sv]
// ----------------------------------------------------------------------------
// mnhr_pkg: shared types and codes for the mesh next-hop resolver
// transaction payloads, request modes, register indexes and the command and
// status groups between the controller and the datapath
// ----------------------------------------------------------------------------
package mnhr_pkg;

    localparam int MAC_W     = 48;
    localparam int MODE_W    = 4;
    localparam int CSLOT_W   = 3;
    localparam int RSLOT_W   = 4;
    localparam int CFG_IDX_W = 2;

    // request modes
    localparam logic [MODE_W-1:0] MODE_RESOLVE    = 4'd0;
    localparam logic [MODE_W-1:0] MODE_NEIGHBOURS = 4'd1;
    localparam logic [MODE_W-1:0] MODE_PARENT     = 4'd2;
    localparam logic [MODE_W-1:0] MODE_CHILDREN   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_DIRECT     = 4'd4;
    localparam logic [MODE_W-1:0] MODE_SET_PARENT = 4'd5;
    localparam logic [MODE_W-1:0] MODE_CLR_PARENT = 4'd6;
    localparam logic [MODE_W-1:0] MODE_SET_CHILD  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_CLR_CHILD  = 4'd8;
    localparam logic [MODE_W-1:0] MODE_WR_ROUTE   = 4'd9;
    localparam logic [MODE_W-1:0] MODE_CLR_ROUTE  = 4'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IS_ROOT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_ALIAS  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [MAC_W-1:0]   target_mac;
        logic [MAC_W-1:0]   last_hop_mac;
        logic [CSLOT_W-1:0] child_slot;
        logic [RSLOT_W-1:0] route_slot;
        logic [MAC_W-1:0]   entry_mac;
    } in_item_t;

    typedef struct packed {
        logic [MAC_W-1:0] next_hop_mac;
        logic             hop_valid;
        logic             last_of_run;
    } out_item_t;

    typedef struct packed {
        logic latch_item;
        logic ld_pend_parent;
        logic ld_pend_target;
        logic ld_pend_child;
        logic push_pend;
        logic finish;
        logic cnt_clr;
        logic c_inc;
        logic r_clr;
        logic r_inc;
        logic wr_parent;
        logic clr_parent;
        logic wr_child;
        logic clr_child;
        logic wr_route;
        logic clr_route;
        logic wipe_route;
        logic clr_ram;
        logic rd_route;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic is_own;
        logic is_bcast;
        logic is_alias;
        logic parent_match;
        logic own_is_root;
        logic parent_present;
        logic cok;
        logic rok;
        logic child_present;
        logic child_match;
        logic route_hit;
        logic cand_child;
        logic cand_parent;
        logic pend_valid;
        logic out_free;
        logic c_last;
        logic r_last;
        logic clr_last;
    } dp_status_t;

endpackage

[hdl/mnhr_ram.sv]
// ----------------------------------------------------------------------------
// mnhr_ram: generic single-port-write, single-port-read RAM
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mnhr_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 128
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hdl/mnhr_datapath.sv]
// ----------------------------------------------------------------------------
// mnhr_datapath: neighbour tables, route memory, counters and result register
// carries out the controller's commands and reports compare results
// ----------------------------------------------------------------------------
module mnhr_datapath #(
    parameter int MAX_CHILDREN     = 8,
    parameter int ROUTES_PER_CHILD = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mnhr_pkg::in_item_t                  s_item,
    input  logic                                cfg_we,
    input  logic [mnhr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mnhr_pkg::MAC_W-1:0]          cfg_wdata,
    input  mnhr_pkg::dp_cmd_t                   cmd,
    output mnhr_pkg::dp_status_t                status,
    input  logic                                m_ready,
    output logic                                m_valid,
    output mnhr_pkg::out_item_t                 m_item
);
    import mnhr_pkg::*;

    localparam int DEPTH = MAX_CHILDREN * ROUTES_PER_CHILD;
    localparam int CW    = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
    localparam int RW    = (ROUTES_PER_CHILD > 1) ? $clog2(ROUTES_PER_CHILD) : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RAM_W = MAC_W + 1;

    in_item_t         item_reg;
    logic [MAC_W-1:0] own_mac_reg;
    logic             own_is_root_reg;
    logic [MAC_W-1:0] root_alias_reg;

    logic             parent_present_reg;
    logic [MAC_W-1:0] parent_addr_reg;
    logic             child_present_reg [MAX_CHILDREN];
    logic [MAC_W-1:0] child_addr_reg [MAX_CHILDREN];

    logic [CW-1:0]    c_cnt_reg;
    logic [RW-1:0]    r_cnt_reg;
    logic [AW-1:0]    clr_cnt_reg;

    logic             pend_valid_reg;
    logic [MAC_W-1:0] pend_mac_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;

    logic [CW-1:0]    cs_idx;
    logic             cok;
    logic             rok;
    logic             excl;
    logic             incl_parent;
    logic [MAC_W-1:0] cur_child;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [RAM_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [RAM_W-1:0] ram_rdata;
    logic             out_free;

    assign cs_idx      = CW'(item_reg.child_slot);
    assign cok         = int'(item_reg.child_slot) < MAX_CHILDREN;
    assign rok         = cok && (int'(item_reg.route_slot) < ROUTES_PER_CHILD);
    assign excl        = item_reg.mode == MODE_RESOLVE;
    assign incl_parent = item_reg.mode != MODE_CHILDREN;
    assign cur_child   = child_addr_reg[c_cnt_reg];
    assign out_free    = !out_valid_reg || m_ready;

    // route memory write and read selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = AW'(int'(cs_idx) * ROUTES_PER_CHILD + int'(item_reg.route_slot));
        ram_wdata = '0;
        if (cmd.clr_ram) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
        end else if (cmd.wipe_route) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(int'(cs_idx) * ROUTES_PER_CHILD + int'(r_cnt_reg));
        end else if (cmd.wr_route) begin
            ram_we    = 1'b1;
            ram_wdata = {1'b1, item_reg.entry_mac};
        end else if (cmd.clr_route) begin
            ram_we    = 1'b1;
        end
    end

    assign ram_raddr = AW'(int'(c_cnt_reg) * ROUTES_PER_CHILD + int'(r_cnt_reg));

    mnhr_ram #(
        .WIDTH (RAM_W),
        .DEPTH (DEPTH)
    ) u_route_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        status                = '0;
        status.mode           = item_reg.mode;
        status.is_own         = item_reg.target_mac == own_mac_reg;
        status.is_bcast       = item_reg.target_mac == {MAC_W{1'b1}};
        status.is_alias       = item_reg.target_mac == root_alias_reg;
        status.parent_match   = parent_present_reg && (parent_addr_reg == item_reg.target_mac);
        status.own_is_root    = own_is_root_reg;
        status.parent_present = parent_present_reg;
        status.cok            = cok;
        status.rok            = rok;
        status.child_present  = child_present_reg[c_cnt_reg];
        status.child_match    = cur_child == item_reg.target_mac;
        status.route_hit      = ram_rdata[MAC_W] && (ram_rdata[MAC_W-1:0] == item_reg.target_mac);
        status.cand_child     = child_present_reg[c_cnt_reg]
                                && !(excl && (cur_child == item_reg.last_hop_mac));
        status.cand_parent    = incl_parent && parent_present_reg
                                && !(excl && (parent_addr_reg == item_reg.last_hop_mac));
        status.pend_valid     = pend_valid_reg;
        status.out_free       = out_free;
        status.c_last         = c_cnt_reg == CW'(MAX_CHILDREN - 1);
        status.r_last         = r_cnt_reg == RW'(ROUTES_PER_CHILD - 1);
        status.clr_last       = clr_cnt_reg == AW'(DEPTH - 1);
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.latch_item) begin
            item_reg <= s_item;
        end
        if (cmd.wr_parent) begin
            parent_addr_reg <= item_reg.entry_mac;
        end
        if (cmd.wr_child) begin
            child_addr_reg[cs_idx] <= item_reg.entry_mac;
        end
        if (cmd.ld_pend_parent) begin
            pend_mac_reg <= parent_addr_reg;
        end else if (cmd.ld_pend_target) begin
            pend_mac_reg <= item_reg.target_mac;
        end else if (cmd.ld_pend_child) begin
            pend_mac_reg <= cur_child;
        end
        if (cmd.push_pend) begin
            out_item_reg <= '{next_hop_mac: pend_mac_reg, hop_valid: 1'b1, last_of_run: 1'b0};
        end else if (cmd.finish) begin
            out_item_reg <= pend_valid_reg
                ? '{next_hop_mac: pend_mac_reg, hop_valid: 1'b1, last_of_run: 1'b1}
                : '{next_hop_mac: '0, hop_valid: 1'b0, last_of_run: 1'b1};
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_mac_reg        <= '0;
            own_is_root_reg    <= 1'b0;
            root_alias_reg     <= '0;
            parent_present_reg <= 1'b0;
            for (int i = 0; i < MAX_CHILDREN; i++) begin
                child_present_reg[i] <= 1'b0;
            end
            c_cnt_reg          <= '0;
            r_cnt_reg          <= '0;
            clr_cnt_reg        <= '0;
            pend_valid_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_OWN_MAC:     own_mac_reg     <= cfg_wdata;
                    CFG_OWN_IS_ROOT: own_is_root_reg <= cfg_wdata[0];
                    CFG_ROOT_ALIAS:  root_alias_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.wr_parent) begin
                parent_present_reg <= 1'b1;
            end else if (cmd.clr_parent) begin
                parent_present_reg <= 1'b0;
            end
            if (cmd.wr_child) begin
                child_present_reg[cs_idx] <= 1'b1;
            end else if (cmd.clr_child) begin
                child_present_reg[cs_idx] <= 1'b0;
            end
            if (cmd.cnt_clr) begin
                c_cnt_reg <= '0;
            end else if (cmd.c_inc) begin
                c_cnt_reg <= c_cnt_reg + 1'b1;
            end
            if (cmd.cnt_clr || cmd.r_clr) begin
                r_cnt_reg <= '0;
            end else if (cmd.r_inc || cmd.wipe_route) begin
                r_cnt_reg <= r_cnt_reg + 1'b1;
            end
            if (cmd.clr_ram) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.ld_pend_parent || cmd.ld_pend_target || cmd.ld_pend_child) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.latch_item) begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.push_pend || cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

[hdl/mnhr_ctrl.sv]
// ----------------------------------------------------------------------------
// mnhr_ctrl: request sequencer
// clearing pass, mode decode, child sweep, route search and result hand-off
// ----------------------------------------------------------------------------
module mnhr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mnhr_pkg::dp_status_t status,
    output mnhr_pkg::dp_cmd_t    cmd
);
    import mnhr_pkg::*;

    localparam logic [3:0] ST_CLEAR     = 4'd0;
    localparam logic [3:0] ST_IDLE      = 4'd1;
    localparam logic [3:0] ST_DECODE    = 4'd2;
    localparam logic [3:0] ST_WIPE      = 4'd3;
    localparam logic [3:0] ST_SWEEP     = 4'd4;
    localparam logic [3:0] ST_SWP_PAR   = 4'd5;
    localparam logic [3:0] ST_SEARCH    = 4'd6;
    localparam logic [3:0] ST_ROUTE_RD  = 4'd7;
    localparam logic [3:0] ST_ROUTE_CMP = 4'd8;
    localparam logic [3:0] ST_FINISH    = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_ram = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch_item = 1'b1;
                    state_next     = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.cnt_clr = 1'b1;
                state_next  = ST_IDLE;
                case (status.mode)
                    MODE_RESOLVE: begin
                        if (status.is_own) begin
                            state_next = ST_FINISH;
                        end else if (status.is_bcast) begin
                            state_next = ST_SWEEP;
                        end else if (status.is_alias) begin
                            cmd.ld_pend_parent = !status.own_is_root && status.parent_present;
                            state_next         = ST_FINISH;
                        end else if (status.parent_match) begin
                            cmd.ld_pend_parent = 1'b1;
                            state_next         = ST_FINISH;
                        end else begin
                            state_next = ST_SEARCH;
                        end
                    end
                    MODE_NEIGHBOURS, MODE_CHILDREN: state_next = ST_SWEEP;
                    MODE_PARENT: begin
                        cmd.ld_pend_parent = status.parent_present;
                        state_next         = ST_FINISH;
                    end
                    MODE_DIRECT: begin
                        cmd.ld_pend_target = !status.is_own;
                        state_next         = ST_FINISH;
                    end
                    MODE_SET_PARENT: cmd.wr_parent  = 1'b1;
                    MODE_CLR_PARENT: cmd.clr_parent = 1'b1;
                    MODE_SET_CHILD:  cmd.wr_child   = status.cok;
                    MODE_CLR_CHILD: begin
                        if (status.cok) begin
                            cmd.clr_child = 1'b1;
                            state_next    = ST_WIPE;
                        end
                    end
                    MODE_WR_ROUTE:  cmd.wr_route  = status.rok;
                    MODE_CLR_ROUTE: cmd.clr_route = status.rok;
                    default: ;
                endcase
            end
            ST_WIPE: begin
                cmd.wipe_route = 1'b1;
                if (status.r_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                // hold while a found hop cannot displace the one already pending
                if (!status.cand_child || !status.pend_valid || status.out_free) begin
                    if (status.cand_child) begin
                        cmd.push_pend     = status.pend_valid;
                        cmd.ld_pend_child = 1'b1;
                    end
                    if (status.c_last) begin
                        state_next = ST_SWP_PAR;
                    end else begin
                        cmd.c_inc = 1'b1;
                    end
                end
            end
            ST_SWP_PAR: begin
                if (!status.cand_parent || !status.pend_valid || status.out_free) begin
                    if (status.cand_parent) begin
                        cmd.push_pend      = status.pend_valid;
                        cmd.ld_pend_parent = 1'b1;
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_SEARCH: begin
                if (!status.child_present) begin
                    if (status.c_last) begin
                        cmd.ld_pend_parent = status.parent_present;
                        state_next         = ST_FINISH;
                    end else begin
                        cmd.c_inc = 1'b1;
                    end
                end else if (status.child_match) begin
                    cmd.ld_pend_child = 1'b1;
                    state_next        = ST_FINISH;
                end else begin
                    cmd.r_clr  = 1'b1;
                    state_next = ST_ROUTE_RD;
                end
            end
            ST_ROUTE_RD: begin
                cmd.rd_route = 1'b1;
                state_next   = ST_ROUTE_CMP;
            end
            ST_ROUTE_CMP: begin
                if (status.route_hit) begin
                    cmd.ld_pend_child = 1'b1;
                    state_next        = ST_FINISH;
                end else if (!status.r_last) begin
                    cmd.r_inc  = 1'b1;
                    state_next = ST_ROUTE_RD;
                end else if (status.c_last) begin
                    cmd.ld_pend_parent = status.parent_present;
                    state_next         = ST_FINISH;
                end else begin
                    cmd.c_inc  = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

[hdl/mesh_next_hop_resolver_top.sv]
// ----------------------------------------------------------------------------
// mesh_next_hop_resolver_top: next-hop selection for a tree-shaped mesh
// how to use it:
// - s_ channel takes one request transaction (route mode or table write)
// - m_ channel gives the hops of a route request, one transaction each,
//   children in slot order then the parent; last_of_run marks the final one,
//   and a request with no hop gives a single transaction with hop_valid low
// - cfg_we / cfg_index / cfg_wdata write own_mac, own_is_root, root_alias_mac
//   while no request is in flight; writes take effect on the next edge
// - table writes are carried out in the decode state after acceptance; clearing a
//   child also wipes its route entries, one by one in the wipe state
// - list and broadcast requests walk the child slots one per cycle, pausing
//   while a found hop meets a stalled m_ channel; results leave one per cycle
// - resolve walks child slots and each present child's route entries through
//   the route memory's single read port, with a read state and a compare
//   state for each entry
// - after reset the route memory is cleared entry by entry with s_ready low;
//   configuration writes are taken meanwhile
// - a stalled m_ channel holds its transaction; the walk pauses with one hop
//   pending, and the next request is accepted while the last result waits
// ----------------------------------------------------------------------------
module mesh_next_hop_resolver_top #(
    parameter int MAX_CHILDREN     = 8,
    parameter int ROUTES_PER_CHILD = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  mnhr_pkg::in_item_t             s_item,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output mnhr_pkg::out_item_t            m_item,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [mnhr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mnhr_pkg::MAC_W-1:0]     cfg_wdata
);
    import mnhr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: owns s_ready and decides every step of a request
    mnhr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // tables, route memory, counters and the output register
    mnhr_datapath #(
        .MAX_CHILDREN     (MAX_CHILDREN),
        .ROUTES_PER_CHILD (ROUTES_PER_CHILD)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_item    (m_item)
    );

endmodule

[hdl/mnhr_checker.sv]
// ----------------------------------------------------------------------------
// mnhr_checker: port-level checks for the resolver
// bound to the top level, watches the request and result channels
// ----------------------------------------------------------------------------
module mnhr_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input mnhr_pkg::out_item_t m_item,
    input logic                m_valid,
    input logic                m_ready
);
    import mnhr_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // a no-hop result is the whole run and carries a zero address
    a_nohop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.hop_valid |-> m_item.last_of_run && (m_item.next_hop_mac == '0))
        else $error("no-hop result not alone");

    // one request at a time
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    // reset empties the output and starts the clearing pass
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("not quiet after reset");

endmodule

bind mesh_next_hop_resolver_top mnhr_checker u_mnhr_checker (.*);
